// ===== rtl/core/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_FULL        = 2'd1,
		ST_NOT_IN_POOL = 2'd2,
		ST_DOUBLE_FREE = 2'd3
	} status_t;

	// Request operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Configuration register indexes
	localparam logic [0:0] REG_POOL_BASE   = 1'b0;
	localparam logic [0:0] REG_ENTRY_BYTES = 1'b1;

	localparam logic [31:0] ALL_FREE          = 32'hFFFF_FFFF;
	localparam int          BITS_PER_WORD     = 32;
	localparam logic [15:0] ENTRY_BYTES_RESET = 16'd16;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_MUL,
		S_A_ADD,
		S_F_LEN,
		S_F_CHK,
		S_F_DIV,
		S_F_WCHK,
		S_F_RMW,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/bsa_if.sv =====
`default_nettype none

// Request channel: operation and address to release
interface bsa_req_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] release_address;

	modport source(output valid, operation, release_address, input ready);
	modport sink(input valid, operation, release_address, output ready);
endinterface

// Response channel: one beat per request
interface bsa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [7:0]  entry_index;
	logic [1:0]  status;

	modport source(output valid, granted_address, entry_index, status, input ready);
	modport sink(input valid, granted_address, entry_index, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bitmap_slab_allocator.sv =====
// Bitmap slab allocator: a pool of ENTRIES fixed-size objects tracked by a
// free bitmap (1 = free) held in a MAP_WORDS x 32 synchronous memory.
// req channel: operation 0 allocates the lowest free entry, operation 1
// frees the entry holding release_address. rsp channel: one beat per
// request with granted_address, entry_index and status.
// cfg port: cfg_we/cfg_index/cfg_wdata write pool_base (0) and
// entry_bytes (1); write only while no request is in flight.
// Allocate scans the bitmap one word at a time (memory read, then
// lowest-bit search and write-back), then multiplies and adds to form the
// address; a full pool answers once every word has been scanned.
// Free range-checks the address, then runs a restoring divider that
// retires one quotient bit per cycle; an address outside the pool skips it.
// One request is worked at a time; req.ready is high only when the
// sequencer is idle, even while a response waits in the output register.
// Reset: the bitmap reads as all free (per-word valid flops), pool_base
// is 0 and entry_bytes is 16; no clearing pass is needed.
// A stalled rsp holds its beat; the next request may be accepted and
// worked, and its result waits until the output register drains.
`default_nettype none

module bitmap_slab_allocator import bsa_pkg::*; #(
	parameter int MAP_WORDS = 8,
	parameter int ENTRIES   = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	bsa_req_if.sink      req,
	bsa_rsp_if.source    rsp,
	input  wire          cfg_we,
	input  wire  [0:0]   cfg_index,
	input  wire  [31:0]  cfg_wdata
);

	localparam int EW = $clog2(ENTRIES);
	localparam int LW = EW + 16;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int NW = AW + 5;
	localparam int CW = $clog2(EW);

	// Configuration registers
	logic [31:0] base_q;
	logic [15:0] eb_q;

	// Bitmap memory and per-word valid flops
	logic [31:0]          mem [MAP_WORDS];
	logic [MAP_WORDS-1:0] vld_q;
	logic [31:0]          rd_data_s1;
	logic                 rd_vld_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;

	// Sequencer and datapath registers
	state_t        state_q, state_d;
	logic [31:0]   addr_q;
	logic [AW-1:0] w_q;
	logic [NW-1:0] ent_q;
	logic [NW+15:0] prod_q;
	logic [31:0]   off_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] rem_q;
	logic [LW-1:0] dsh_q;
	logic [EW-1:0] quo_q;
	logic [CW-1:0] cnt_q;

	logic [31:0]   res_addr_q;
	logic [7:0]    res_idx_q;
	status_t       res_st_q;

	logic          out_vld_q;
	logic [31:0]   out_addr_q;
	logic [7:0]    out_idx_q;
	status_t       out_st_q;

	// Combinational helpers
	logic [31:0]   word_s1;
	logic          found;
	logic [4:0]    low_bit;
	logic [NW-1:0] ent_cand;
	logic          ent_ok;
	logic          last_word;
	logic [31:0]   fw_idx;
	logic          fw_bad;
	logic [31:0]   fw_mask;
	logic          div_ge;
	logic          out_free;
	logic          load_out;

	// Register configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			eb_q   <= ENTRY_BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POOL_BASE:   base_q <= cfg_wdata;
				REG_ENTRY_BYTES: eb_q   <= cfg_wdata[15:0];
				default:         ;
			endcase
		end
	end

	// Bitmap memory: one read and one write port, registered read data
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= vld_q[rd_addr];
			end
		end
	end

	// Unwritten words read as all free
	assign word_s1 = rd_vld_s1 ? rd_data_s1 : ALL_FREE;

	// Find lowest set bit of the fetched word
	always_comb begin
		found   = 1'b0;
		low_bit = '0;
		for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
			if (word_s1[i]) begin
				found   = 1'b1;
				low_bit = 5'(i);
			end
		end
	end

	assign ent_cand  = {w_q, low_bit};
	assign ent_ok    = found && (32'(ent_cand) < 32'(ENTRIES));
	assign last_word = (32'(w_q) == 32'(MAP_WORDS - 1));

	// Word and bit of the entry being freed
	assign fw_idx  = 32'(quo_q) >> 5;
	assign fw_bad  = (fw_idx >= 32'(MAP_WORDS));
	assign fw_mask = 32'd1 << quo_q[4:0];

	assign div_ge   = (rem_q >= dsh_q);
	assign out_free = !out_vld_q || rsp.ready;
	assign load_out = (state_q == S_DONE) && out_free;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory controls
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = w_q;
		wr_en   = 1'b0;
		wr_addr = w_q;
		wr_data = word_s1 & ~(32'd1 << low_bit);
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = (req.operation == OP_ALLOC) ? S_A_RD : S_F_LEN;
				end
			end
			S_A_RD: begin
				rd_en   = 1'b1;
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				if (ent_ok) begin
					wr_en   = 1'b1;
					state_d = S_A_MUL;
				end else if (last_word) begin
					state_d = S_DONE;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_MUL: state_d = S_A_ADD;
			S_A_ADD: state_d = S_DONE;
			S_F_LEN: state_d = S_F_CHK;
			S_F_CHK: begin
				state_d = (off_q >= 32'(len_q)) ? S_DONE : S_F_DIV;
			end
			S_F_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_F_WCHK;
				end
			end
			S_F_WCHK: begin
				if (fw_bad) begin
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = fw_idx[AW-1:0];
					state_d = S_F_RMW;
				end
			end
			S_F_RMW: begin
				wr_en   = 1'b1;
				wr_addr = fw_idx[AW-1:0];
				wr_data = word_s1 | fw_mask;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Datapath: scan, multiply, range check, divide, build result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				addr_q <= req.release_address;
				w_q    <= '0;
			end
			S_A_CHK: begin
				ent_q <= ent_cand;
				if (!ent_ok) begin
					w_q        <= w_q + AW'(1);
					res_addr_q <= '0;
					res_idx_q  <= '0;
					res_st_q   <= ST_FULL;
				end
			end
			S_A_MUL: begin
				prod_q <= (NW + 16)'(ent_q) * (NW + 16)'(eb_q);
			end
			S_A_ADD: begin
				res_addr_q <= base_q + 32'(prod_q);
				res_idx_q  <= 8'(ent_q);
				res_st_q   <= ST_OK;
			end
			S_F_LEN: begin
				len_q <= LW'(ENTRIES) * LW'(eb_q);
				off_q <= addr_q - base_q;
			end
			S_F_CHK: begin
				rem_q      <= off_q[LW-1:0];
				dsh_q      <= LW'(eb_q) << (EW - 1);
				cnt_q      <= CW'(EW - 1);
				res_addr_q <= '0;
				res_idx_q  <= '0;
				res_st_q   <= ST_NOT_IN_POOL;
			end
			S_F_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[EW-2:0], div_ge};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - CW'(1);
			end
			S_F_RMW: begin
				res_addr_q <= '0;
				res_idx_q  <= 8'(quo_q);
				res_st_q   <= ((word_s1 & fw_mask) != '0) ? ST_DOUBLE_FREE : ST_OK;
			end
			default: ;
		endcase
	end

	// Output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_addr_q <= res_addr_q;
			out_idx_q  <= res_idx_q;
			out_st_q   <= res_st_q;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.entry_index     = out_idx_q;
	assign rsp.status          = out_st_q;

endmodule

`default_nettype wire

// ===== rtl/core/bsa_checker.sv =====
`default_nettype none

module bsa_checker import bsa_pkg::*; (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] granted_address,
	input wire [7:0]  entry_index,
	input wire [1:0]  status
);

	// A stalled response beat stays valid
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response beat dropped while stalled");

	// One request at a time: ready drops after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another is in flight");

	// A response whose status is not OK carries a zero address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> granted_address == 32'd0)
		else $error("nonzero address on a failed or free response");

	// Full and out-of-pool responses carry no entry
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == ST_FULL) || (status == ST_NOT_IN_POOL))
		|-> entry_index == 8'd0)
		else $error("entry index set on full or out-of-pool response");

endmodule

bind bitmap_slab_allocator bsa_checker u_bsa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (req.valid),
	.in_ready        (req.ready),
	.out_valid       (rsp.valid),
	.out_ready       (rsp.ready),
	.granted_address (rsp.granted_address),
	.entry_index     (rsp.entry_index),
	.status          (rsp.status)
);

`default_nettype wire

// ===== tb/sv/bitmap_slab_allocator_tb.sv =====
`timescale 1ns / 1ps

module bitmap_slab_allocator_tb;
	import bsa_pkg::*;

	localparam int MAP_WORDS = 8;
	localparam int ENTRIES   = MAP_WORDS * BITS_PER_WORD;
	localparam int IDLE_PCT  = 31;
	localparam int SETTLE    = 2 * MAP_WORDS + 4;

	typedef struct {
		logic [31:0] addr;
		logic [7:0]  index;
		status_t     status;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [31:0] cfg_wdata;

	bsa_req_if req();
	bsa_rsp_if rsp();

	bitmap_slab_allocator #(
		.MAP_WORDS(MAP_WORDS),
		.ENTRIES  (ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req.sink),
		.rsp      (rsp.source),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Shadow copy of the pool: free map and registers
	logic [31:0] free_map [MAP_WORDS];
	logic [31:0] pool_base_m;
	logic [15:0] entry_bytes_m;

	grant_t pending_grants[$];
	int     fail_count;
	int     beats_checked;
	int     n_granted, n_full, n_released, n_outside, n_double;
	bit     no_gaps;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Work out the result of one accepted request and update the shadow pool
	task automatic predict_grant(input logic op, input logic [31:0] addr);
		grant_t      res;
		logic [31:0] entry_no;
		logic [31:0] offset;
		logic [63:0] span;
		int          word_no;
		int          bit_no;
		bit          found;
		res = '{addr: 32'd0, index: 8'd0, status: ST_FULL};
		found = 1'b0;
		if (op == OP_ALLOC) begin
			for (int w = 0; w < MAP_WORDS && !found; w++) begin
				for (int b = 0; b < BITS_PER_WORD && !found; b++) begin
					entry_no = w * BITS_PER_WORD + b;
					if (entry_no < ENTRIES && free_map[w][b]) begin
						found = 1'b1;
						free_map[w][b] = 1'b0;
						res.addr   = pool_base_m + entry_no * entry_bytes_m;
						res.index  = entry_no[7:0];
						res.status = ST_OK;
					end
				end
			end
			if (found)
				n_granted++;
			else
				n_full++;
		end else begin
			span   = ENTRIES * entry_bytes_m;
			offset = addr - pool_base_m;
			res.status = ST_NOT_IN_POOL;
			if (entry_bytes_m != 16'd0 && {32'd0, offset} < span) begin
				entry_no = offset / {16'd0, entry_bytes_m};
				word_no  = entry_no / BITS_PER_WORD;
				bit_no   = entry_no % BITS_PER_WORD;
				if (word_no < MAP_WORDS) begin
					res.index  = entry_no[7:0];
					res.status = free_map[word_no][bit_no] ? ST_DOUBLE_FREE : ST_OK;
					free_map[word_no][bit_no] = 1'b1;
				end
			end
			case (res.status)
				ST_OK:          n_released++;
				ST_DOUBLE_FREE: n_double++;
				default:        n_outside++;
			endcase
		end
		pending_grants.push_back(res);
	endtask

	// Send one request beat, with random gaps ahead of it
	task automatic send_request(input logic op, input logic [31:0] addr);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid           <= 1'b1;
		req.operation       <= op;
		req.release_address <= addr;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_grant(op, addr);
	endtask

	// Drain outstanding work, then write both pool registers
	task automatic set_pool(input logic [31:0] base, input logic [15:0] bytes);
		req.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_POOL_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		pool_base_m = base;
		cfg_index <= REG_ENTRY_BYTES;
		cfg_wdata <= {16'd0, bytes};
		@(posedge clk);
		entry_bytes_m = bytes;
		cfg_we <= 1'b0;
	endtask

	// Random entry whose free bit matches want_free, else a random one
	function automatic int pick_entry(input bit want_free);
		int start;
		int e;
		start = $urandom_range(0, ENTRIES - 1);
		for (int k = 0; k < ENTRIES; k++) begin
			e = (start + k) % ENTRIES;
			if (free_map[e / BITS_PER_WORD][e % BITS_PER_WORD] == want_free)
				return e;
		end
		return start;
	endfunction

	function automatic logic [31:0] byte_of_entry(input int e);
		logic [31:0] inner;
		inner = (entry_bytes_m == 16'd0) ? 32'd0 : $urandom_range(0, entry_bytes_m - 1);
		return pool_base_m + e * entry_bytes_m + inner;
	endfunction

	// Reset defaults: grant order, release inside an entry, double release, range ends
	task automatic test_basic_alloc_free();
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_ALLOC, 32'hFFFF_FFFF);
		send_request(OP_FREE, 32'd31);
		send_request(OP_FREE, 32'd16);
		send_request(OP_FREE, 32'd0);
		send_request(OP_FREE, 32'd4095);
		send_request(OP_FREE, 32'd4096);
		send_request(OP_FREE, 32'hFFFF_FFFF);
	endtask

	// Largest entries with a base near the top: addresses wrap past zero
	task automatic test_range_and_wrap();
		logic [31:0] base;
		base = 32'hFFFF_FF00;
		set_pool(base, 16'hFFFF);
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_FREE, base + 32'd65535 + 32'd100);
		send_request(OP_FREE, base - 32'd1);
		send_request(OP_FREE, base + ENTRIES * 32'd65535 - 32'd1);
		send_request(OP_FREE, base + ENTRIES * 32'd65535);
	endtask

	// One-byte entries, then zero-size entries where every release is outside
	task automatic test_narrow_and_empty_entries();
		set_pool(32'h0000_1234, 16'd1);
		send_request(OP_FREE, 32'h0000_1234);
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_FREE, 32'h0000_1234 + ENTRIES - 1);
		send_request(OP_FREE, 32'h0000_1234 + ENTRIES);
		set_pool(32'hA5A5_5A5A, 16'd0);
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_ALLOC, 32'd0);
		send_request(OP_FREE, 32'hA5A5_5A5A);
	endtask

	// Phases of fill, churn and drain traffic under changing pool settings
	task automatic test_random_traffic();
		int          alloc_pct;
		int          span_items;
		int          kind;
		logic [31:0] base;
		logic [15:0] bytes;
		logic [31:0] addr;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       begin base = $urandom; bytes = 16'd16; end
				1:       begin base = 32'd0; bytes = 16'd1; end
				2:       begin base = 32'hFFFF_FFFF; bytes = 16'hFFFF; end
				4:       begin base = $urandom; bytes = 16'($urandom_range(1, 64)); end
				default: begin base = $urandom; bytes = 16'($urandom_range(1, 65535)); end
			endcase
			case (phase)
				0, 1, 4, 7: alloc_pct = 85;
				2, 5:       alloc_pct = 50;
				default:    alloc_pct = 15;
			endcase
			set_pool(base, bytes);
			no_gaps = (phase == 2);
			span_items = $urandom_range(200, 240);
			for (int i = 0; i < span_items; i++) begin
				addr = $urandom;
				if ($urandom_range(0, 99) < alloc_pct) begin
					send_request(OP_ALLOC, addr);
				end else begin
					kind = $urandom_range(0, 9);
					if (kind <= 6)
						addr = byte_of_entry(pick_entry(1'b0));
					else if (kind == 7)
						addr = byte_of_entry(pick_entry(1'b1));
					else if (kind == 9)
						addr = $urandom_range(0, 1) ?
							pool_base_m + ENTRIES * entry_bytes_m + $urandom_range(0, 3) :
							pool_base_m - 32'd1 - $urandom_range(0, 3);
					send_request(OP_FREE, addr);
				end
			end
			no_gaps = 1'b0;
		end
	endtask

	// Throttle the response side
	always @(posedge clk)
		rsp.ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);

	// Compare each response beat with the oldest prediction
	always @(posedge clk) begin
		grant_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			beats_checked++;
			if (pending_grants.size() == 0) begin
				$error("response beat with no request outstanding");
				fail_count++;
			end else begin
				want = pending_grants.pop_front();
				if (rsp.granted_address !== want.addr) begin
					$error("granted_address: expected %h, got %h", want.addr, rsp.granted_address);
					fail_count++;
				end
				if (rsp.entry_index !== want.index) begin
					$error("entry_index: expected %0d, got %0d", want.index, rsp.entry_index);
					fail_count++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		req.valid           = 1'b0;
		req.operation       = OP_ALLOC;
		req.release_address = 32'd0;
		cfg_we              = 1'b0;
		cfg_index           = REG_POOL_BASE;
		cfg_wdata           = 32'd0;
		no_gaps             = 1'b0;
		fail_count          = 0;
		beats_checked       = 0;
		pool_base_m         = 32'd0;
		entry_bytes_m       = ENTRY_BYTES_RESET;
		for (int w = 0; w < MAP_WORDS; w++)
			free_map[w] = ALL_FREE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_alloc_free();
		test_range_and_wrap();
		test_narrow_and_empty_entries();
		test_random_traffic();

		// Let the last responses come back, then watch for strays
		req.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d responses: %0d grants, %0d full, %0d releases,",
			beats_checked, n_granted, n_full, n_released);
		$display("  %0d double releases, %0d outside the pool, over 11 pool settings",
			n_double, n_outside);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
